[rtl/usvt_pkg.sv]
// Package with the shared constants and types of the unique value set table.
package usvt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int LIMIT_W = 5;
    localparam int CMD_W   = 1;
    localparam int IN_W    = ((CMD_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W   = ((1 + LIMIT_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        OP_REMOVE = 1'b0,
        OP_ADD    = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    typedef struct packed {
        logic                     compare;
        logic                     shift;
        logic                     append;
        logic signed [VAL_W-1:0]  value;
        logic        [CNT_W-1:0]  held;
    } cell_cmd_t;

endpackage

[rtl/usvt_cell.sv]
// One table cell: holds one entry, compares it and shifts it towards the front.
module usvt_cell
(
    input  logic                                 clk,
    input  usvt_pkg::cell_cmd_t                  cmd,
    input  logic [usvt_pkg::IDX_W-1:0]           idx,
    input  logic                                 seen_in,
    input  logic signed [usvt_pkg::VAL_W-1:0]    next_entry,
    output logic                                 seen_out,
    output logic signed [usvt_pkg::VAL_W-1:0]    entry
);

    logic signed [usvt_pkg::VAL_W-1:0] entry_reg;
    logic signed [usvt_pkg::VAL_W-1:0] entry_next;
    logic                              match_reg;
    logic                              match_next;
    logic                              live;

    assign live     = usvt_pkg::CNT_W'(idx) < cmd.held;
    assign seen_out = seen_in | match_reg;
    assign entry    = entry_reg;

    always_comb
    begin
        match_next = match_reg;
        if (cmd.compare)
        begin
            match_next = live && (entry_reg == cmd.value);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.shift && seen_out)
        begin
            entry_next = next_entry;
        end
        else if (cmd.append && (usvt_pkg::CNT_W'(idx) == cmd.held))
        begin
            entry_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

endmodule

[rtl/unique_value_set_table.sv]
// Top level of the unique value set table: control, count and the row of cells.
//
// Input words arrive on s_axis with the operation in bit 0 of tdata (0 removes,
// 1 adds) and the signed 32-bit value in bits 32 to 1. Every word gives one
// result word on m_axis: bit 0 is the success flag and bits 5 to 1 the number
// of entries held afterwards.
// A word is compared against all cells in the cycle it is accepted; in the
// ST_UPDATE state that follows, once the output register is free, the cells
// shift down to close a gap or the new value is written at the end, and the
// result is loaded into the output register. A new word is taken only after
// that update, since the compare and update steps share the one row of cells.
// The limit register is written through cfg_we and cfg_wdata; the user does so
// only while idle, unchecked by the block; writes apply at once, reset sets 16.
// Reset empties the set, clears the output valid flag and returns the control
// to idle; entries above the count are never read and need no clearing.
// When the receiver holds m_axis_tready low the result waits in the output
// register; one further word is still accepted and compared, and its update
// waits until the output register is free.
module unique_value_set_table
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [usvt_pkg::LIMIT_W-1:0]      cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: opcode (1), value (32), zero padding.
    input  logic [usvt_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: ok (1), count (5), zero padding.
    output logic [usvt_pkg::OUT_W-1:0]        m_axis_tdata
);

    usvt_pkg::state_t                   state_reg;
    usvt_pkg::state_t                   state_next;
    logic [usvt_pkg::LIMIT_W-1:0]       limit_reg;
    logic [usvt_pkg::LIMIT_W-1:0]       limit_next;
    logic [usvt_pkg::CNT_W-1:0]         held_reg;
    logic [usvt_pkg::CNT_W-1:0]         held_next;
    usvt_pkg::op_t                      op_reg;
    usvt_pkg::op_t                      op_next;
    logic signed [usvt_pkg::VAL_W-1:0]  value_reg;
    logic signed [usvt_pkg::VAL_W-1:0]  value_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_ok_reg;
    logic                               out_ok_next;
    logic [usvt_pkg::LIMIT_W-1:0]       out_count_reg;
    logic [usvt_pkg::LIMIT_W-1:0]       out_count_next;

    logic                               in_fire;
    logic                               update;
    logic                               found;
    logic                               room;
    int unsigned                        cap;
    usvt_pkg::cell_cmd_t                cmd;

    logic                               seen [usvt_pkg::DEPTH+1];
    logic signed [usvt_pkg::VAL_W-1:0]  ent  [usvt_pkg::DEPTH];

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign found   = seen[usvt_pkg::DEPTH];
    assign cap     = (32'(limit_reg) > 32'(usvt_pkg::DEPTH)) ? 32'(usvt_pkg::DEPTH)
                                                             : 32'(limit_reg);
    assign room    = 32'(held_reg) < cap;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            usvt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = usvt_pkg::ST_UPDATE;
                end
            end
            usvt_pkg::ST_UPDATE:
            begin
                if (update)
                begin
                    state_next = usvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = usvt_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        update        = 1'b0;
        case (state_reg)
            usvt_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            usvt_pkg::ST_UPDATE:
            begin
                update = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                update        = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cmd.compare = in_fire;
        cmd.shift   = update && (op_reg == usvt_pkg::OP_REMOVE) && found;
        cmd.append  = update && (op_reg == usvt_pkg::OP_ADD) && !found && room;
        cmd.value   = in_fire ? s_axis_tdata[usvt_pkg::CMD_W +: usvt_pkg::VAL_W] : value_reg;
        cmd.held    = held_reg;
    end

    always_comb
    begin
        op_next    = op_reg;
        value_next = value_reg;
        if (in_fire)
        begin
            op_next    = usvt_pkg::op_t'(s_axis_tdata[usvt_pkg::CMD_W-1:0]);
            value_next = s_axis_tdata[usvt_pkg::CMD_W +: usvt_pkg::VAL_W];
        end
    end

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_we)
        begin
            limit_next = cfg_wdata;
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.shift)
        begin
            held_next = held_reg - usvt_pkg::CNT_W'(1);
        end
        else if (cmd.append)
        begin
            held_next = held_reg + usvt_pkg::CNT_W'(1);
        end
        if (update)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = found || cmd.append;
            out_count_next = usvt_pkg::LIMIT_W'(held_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= usvt_pkg::ST_IDLE;
            limit_reg     <= usvt_pkg::LIMIT_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    assign seen[0] = 1'b0;

    for (genvar k = 0; k < usvt_pkg::DEPTH; k++)
    begin : g_cell
        logic signed [usvt_pkg::VAL_W-1:0] next_in;

        if (k == usvt_pkg::DEPTH - 1)
        begin : g_last
            assign next_in = ent[k];
        end
        else
        begin : g_mid
            assign next_in = ent[k+1];
        end

        usvt_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (usvt_pkg::IDX_W'(k)),
            .seen_in    (seen[k]),
            .next_entry (next_in),
            .seen_out   (seen[k+1]),
            .entry      (ent[k])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = usvt_pkg::OUT_W'({out_count_reg, out_ok_reg});

endmodule
